### hw/rtl/triangle_pixel_depth_shader_macros.svh
// Assertion macros for the triangle pixel depth shader.
// Included by the RTL files that carry concurrent assertions.
`ifndef TRIANGLE_PIXEL_DEPTH_SHADER_MACROS_SVH
`define TRIANGLE_PIXEL_DEPTH_SHADER_MACROS_SVH
`ifndef SYNTHESIS
`define TPDS_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tpds assertion failed");
`define TPDS_ASSERT(lbl, prop) `TPDS_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define TPDS_ASSERT_CLK(lbl, clk, rstn, prop)
`define TPDS_ASSERT(lbl, prop)
`endif
`endif

### hw/rtl/tpds_pkg.sv
// Shared types, constants and helper functions of the triangle pixel depth shader.
// No dependencies.
package tpds_pkg;

  localparam int SCREEN_WIDTH_DEF  = 512;
  localparam int SCREEN_HEIGHT_DEF = 512;

  localparam int COORD_W    = 9;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 12;
  localparam int EW         = 21;  // edge value / full area
  localparam int WW         = 23;  // barycentric numerator
  localparam int MULA_W     = 17;  // attribute operand of the multiplier
  localparam int PROD_W     = WW + MULA_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int QUO_W      = 17;  // quotient magnitude bits
  localparam int DEN_W      = 21;
  localparam int ADDR_MAX_W = 22;
  localparam int QDEPTH     = 2;
  localparam int STORE_W    = DEPTH_W + 1;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic signed [QUO_W:0] DEPTH_MAX = 18'sd32767;
  localparam logic signed [QUO_W:0] DEPTH_MIN = -18'sd32767;
  localparam logic signed [QUO_W:0] COLOR_MAX = 18'sd4095;

  typedef enum logic [1:0] {OP_NONE, OP_PIXEL, OP_CLEAR} op_e;

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_MUL, ST_DIVGO, ST_DIV, ST_EMIT
  } back_state_e;

  typedef struct packed {
    op_e                                   op;
    logic [2:0][WW-1:0]                    w;
    logic signed [EW-1:0]                  full;
    logic [ADDR_MAX_W-1:0]                 idx;
    logic [2:0][DEPTH_W-1:0]               depth;
    logic [2:0][2:0][COLOR_W-1:0]          color;  // [vertex][channel]
  } entry_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
    logic signed [EW-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W:0]   quo;
  } div_rsp_t;

  function automatic logic signed [EW-1:0] edge2(
    input logic signed [10:0] ax, input logic signed [10:0] ay,
    input logic signed [10:0] bx, input logic signed [10:0] by,
    input logic signed [10:0] cx, input logic signed [10:0] cy);
    logic signed [21:0] p1;
    logic signed [21:0] p2;
    p1 = (bx - ax) * (cy - ay);
    p2 = (cx - ax) * (by - ay);
    return EW'(p1 - p2);
  endfunction

  function automatic logic same_side(input logic signed [WW-1:0] n,
                                     input logic signed [EW-1:0] full);
    return (n == '0) || (n[WW-1] == full[EW-1]);
  endfunction

endpackage

### hw/rtl/tpds_if.sv
// Input and output channel interfaces of the triangle pixel depth shader.
// Depends on tpds_pkg.
interface tpds_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic [1:0]                           vertex_slot;
  logic [tpds_pkg::COORD_W-1:0]         pos_x;
  logic [tpds_pkg::COORD_W-1:0]         pos_y;
  logic signed [tpds_pkg::DEPTH_W-1:0]  vertex_depth_in;
  logic [tpds_pkg::COLOR_W-1:0]         vertex_red;
  logic [tpds_pkg::COLOR_W-1:0]         vertex_green;
  logic [tpds_pkg::COLOR_W-1:0]         vertex_blue;
  modport source (output valid, kind, vertex_slot, pos_x, pos_y, vertex_depth_in,
                  vertex_red, vertex_green, vertex_blue, input ready);
  modport sink (input valid, kind, vertex_slot, pos_x, pos_y, vertex_depth_in,
                vertex_red, vertex_green, vertex_blue, output ready);
endinterface

interface tpds_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 drawn;
  logic [tpds_pkg::COLOR_W-1:0]         pixel_red;
  logic [tpds_pkg::COLOR_W-1:0]         pixel_green;
  logic [tpds_pkg::COLOR_W-1:0]         pixel_blue;
  logic signed [tpds_pkg::DEPTH_W-1:0]  pixel_depth;
  modport source (output valid, drawn, pixel_red, pixel_green, pixel_blue, pixel_depth,
                  input ready);
  modport sink (input valid, drawn, pixel_red, pixel_green, pixel_blue, pixel_depth,
                output ready);
endinterface

### hw/rtl/tpds_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tpds_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/tpds_front.sv
// Front end: takes transactions, holds the triangle corners, classifies pixels.
// Depends on tpds_pkg and tpds_if.
module tpds_front #(
  parameter int SCREEN_WIDTH  = tpds_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tpds_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tpds_in_if.sink          in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output tpds_pkg::entry_t entry_o
);
  logic [2:0][tpds_pkg::COORD_W-1:0]        cx_q, cx_d, cy_q, cy_d;
  logic [2:0][tpds_pkg::DEPTH_W-1:0]        cz_q, cz_d;
  logic [2:0][2:0][tpds_pkg::COLOR_W-1:0]   cc_q, cc_d;
  logic signed [10:0] sx [3];
  logic signed [10:0] sy [3];
  logic signed [10:0] px, py;
  logic signed [tpds_pkg::EW-1:0] full, wa, wg;
  logic signed [tpds_pkg::WW-1:0] wb;
  logic on_screen, in_tri, accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i] = $signed({2'b00, cx_q[i]});
      sy[i] = $signed({2'b00, cy_q[i]});
    end
    px = $signed({2'b00, in_i.pos_x});
    py = $signed({2'b00, in_i.pos_y});
    full = tpds_pkg::edge2(sx[0], sy[0], sx[1], sy[1], sx[2], sy[2]);
    wa   = tpds_pkg::edge2(sx[1], sy[1], sx[2], sy[2], px, py);
    wg   = tpds_pkg::edge2(sx[0], sy[0], sx[1], sy[1], px, py);
    wb   = tpds_pkg::WW'(full) - tpds_pkg::WW'(wa) - tpds_pkg::WW'(wg);
    on_screen = (32'(in_i.pos_x) < SCREEN_WIDTH) && (32'(in_i.pos_y) < SCREEN_HEIGHT);
    in_tri = (full != '0) && tpds_pkg::same_side(tpds_pkg::WW'(wa), full)
          && tpds_pkg::same_side(wb, full) && tpds_pkg::same_side(tpds_pkg::WW'(wg), full);
  end

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    cc_d = cc_q;
    if (accept && in_i.kind == tpds_pkg::KIND_LOAD && in_i.vertex_slot != 2'd3) begin
      cx_d[in_i.vertex_slot]    = in_i.pos_x;
      cy_d[in_i.vertex_slot]    = in_i.pos_y;
      cz_d[in_i.vertex_slot]    = in_i.vertex_depth_in;
      cc_d[in_i.vertex_slot][0] = in_i.vertex_red;
      cc_d[in_i.vertex_slot][1] = in_i.vertex_green;
      cc_d[in_i.vertex_slot][2] = in_i.vertex_blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      cc_q <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
      cc_q <= cc_d;
    end
  end

  always_comb begin
    push_o        = accept;
    entry_o.w[0]  = tpds_pkg::WW'(wa);
    entry_o.w[1]  = wb;
    entry_o.w[2]  = tpds_pkg::WW'(wg);
    entry_o.full  = full;
    entry_o.idx   = tpds_pkg::ADDR_MAX_W'(32'(in_i.pos_y) * SCREEN_WIDTH
                                          + 32'(in_i.pos_x));
    entry_o.depth = cz_q;
    entry_o.color = cc_q;
    case (in_i.kind)
      tpds_pkg::KIND_PIXEL: entry_o.op = (on_screen && in_tri) ? tpds_pkg::OP_PIXEL
                                                               : tpds_pkg::OP_NONE;
      tpds_pkg::KIND_CLEAR: entry_o.op = tpds_pkg::OP_CLEAR;
      default:              entry_o.op = tpds_pkg::OP_NONE;
    endcase
  end
endmodule

### hw/rtl/tpds_queue.sv
// Short FIFO of classified transactions between front and back end.
// Depends on tpds_pkg.
module tpds_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tpds_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output tpds_pkg::entry_t head_o
);
  localparam int PW = $clog2(tpds_pkg::QDEPTH);
  localparam int CW = $clog2(tpds_pkg::QDEPTH + 1);

  tpds_pkg::entry_t mem_q [tpds_pkg::QDEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(tpds_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PW'(tpds_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    if (do_pop)  rptr_d = (rptr_q == PW'(tpds_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= entry_i;
  end
endmodule

### hw/rtl/tpds_div.sv
// Shared restoring divider, one quotient bit a cycle, truncates towards zero.
// Depends on tpds_pkg. Quotient magnitude must stay below 2**QUO_W.
module tpds_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpds_pkg::div_req_t req_i,
  output tpds_pkg::div_rsp_t rsp_o
);
  localparam int CNT_W = $clog2(tpds_pkg::QUO_W);

  logic                          busy_q, done_q, neg_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [tpds_pkg::DEN_W-1:0]    r_q, d_q;
  logic [tpds_pkg::QUO_W-1:0]    nlow_q, q_q;
  logic [tpds_pkg::ACC_W-1:0]    nmag;
  logic [tpds_pkg::DEN_W-1:0]    dmag;
  logic [tpds_pkg::DEN_W:0]      r2;
  logic                          qbit;

  always_comb begin
    nmag = req_i.num[tpds_pkg::ACC_W-1] ? tpds_pkg::ACC_W'(-req_i.num)
                                        : tpds_pkg::ACC_W'(req_i.num);
    dmag = req_i.den[tpds_pkg::EW-1] ? tpds_pkg::DEN_W'(-req_i.den)
                                     : tpds_pkg::DEN_W'(req_i.den);
    r2   = {r_q, nlow_q[tpds_pkg::QUO_W-1]};
    qbit = (r2 >= {1'b0, d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(tpds_pkg::QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q    <= tpds_pkg::DEN_W'(nmag >> tpds_pkg::QUO_W);
      nlow_q <= nmag[tpds_pkg::QUO_W-1:0];
      d_q    <= dmag;
      neg_q  <= req_i.num[tpds_pkg::ACC_W-1] ^ req_i.den[tpds_pkg::EW-1];
      q_q    <= '0;
    end else if (busy_q) begin
      r_q    <= qbit ? tpds_pkg::DEN_W'(r2 - {1'b0, d_q}) : r2[tpds_pkg::DEN_W-1:0];
      nlow_q <= {nlow_q[tpds_pkg::QUO_W-2:0], 1'b0};
      q_q    <= {q_q[tpds_pkg::QUO_W-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
endmodule

### hw/rtl/tpds_back.sv
// Back end: interpolation sequencer, depth test, store sweep and result register.
// Depends on tpds_pkg, tpds_if, the macros header; drives tpds_div and tpds_ram.
`include "triangle_pixel_depth_shader_macros.svh"
module tpds_back #(
  parameter int DEPTH = tpds_pkg::SCREEN_WIDTH_DEF * tpds_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  tpds_pkg::entry_t              head_i,
  output logic                          pop_o,
  output tpds_pkg::div_req_t            div_req_o,
  input  tpds_pkg::div_rsp_t            div_rsp_i,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [$clog2(DEPTH)-1:0]      ram_addr_o,
  output logic [tpds_pkg::STORE_W-1:0]  ram_wdata_o,
  input  logic [tpds_pkg::STORE_W-1:0]  ram_rdata_i,
  tpds_out_if.source                    out_o
);
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  tpds_pkg::back_state_e state_q, state_d;
  tpds_pkg::entry_t ent_q;
  logic [1:0] attr_q, mcnt_q;
  logic signed [tpds_pkg::PROD_W-1:0] prod_q;
  logic signed [tpds_pkg::ACC_W-1:0]  acc_q;
  logic [AW-1:0] sw_q;
  logic sweep_emit_q;
  logic res_drawn_q;
  logic [2:0][tpds_pkg::COLOR_W-1:0] res_col_q;
  logic [tpds_pkg::DEPTH_W-1:0] res_depth_q;
  logic out_valid_q, out_drawn_q;
  logic [2:0][tpds_pkg::COLOR_W-1:0] out_col_q;
  logic [tpds_pkg::DEPTH_W-1:0] out_depth_q;

  logic out_load, depth_fail;
  logic signed [tpds_pkg::MULA_W-1:0] mul_a;
  logic signed [tpds_pkg::WW-1:0]     mul_w;
  logic signed [tpds_pkg::QUO_W:0]    q, dsat, csat;

  // multiplier operands: attribute 0 is depth, 1..3 the colour channels
  always_comb begin
    mul_w = $signed(ent_q.w[mcnt_q]);
    if (attr_q == 2'd0) mul_a = tpds_pkg::MULA_W'($signed(ent_q.depth[mcnt_q]));
    else mul_a = $signed({1'b0, ent_q.color[mcnt_q][attr_q - 2'd1]});
    q = div_rsp_i.quo;
    if (q > tpds_pkg::DEPTH_MAX) dsat = tpds_pkg::DEPTH_MAX;
    else if (q < tpds_pkg::DEPTH_MIN) dsat = tpds_pkg::DEPTH_MIN;
    else dsat = q;
    if (q > tpds_pkg::COLOR_MAX) csat = tpds_pkg::COLOR_MAX;
    else if (q < 0) csat = '0;
    else csat = q;
    depth_fail = ram_rdata_i[tpds_pkg::DEPTH_W]
              && ($signed(ram_rdata_i[tpds_pkg::DEPTH_W-1:0])
                  > $signed(dsat[tpds_pkg::DEPTH_W-1:0]));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpds_pkg::ST_SWEEP: if (sw_q == LAST) state_d = sweep_emit_q ? tpds_pkg::ST_EMIT
                                                                  : tpds_pkg::ST_IDLE;
      tpds_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          unique case (head_i.op)
            tpds_pkg::OP_PIXEL: state_d = tpds_pkg::ST_MUL;
            tpds_pkg::OP_CLEAR: state_d = tpds_pkg::ST_SWEEP;
            default:            state_d = tpds_pkg::ST_EMIT;
          endcase
        end
      end
      tpds_pkg::ST_MUL:   if (mcnt_q == 2'd3) state_d = tpds_pkg::ST_DIVGO;
      tpds_pkg::ST_DIVGO: state_d = tpds_pkg::ST_DIV;
      tpds_pkg::ST_DIV: begin
        if (div_rsp_i.done) begin
          if (attr_q == 2'd0) state_d = depth_fail ? tpds_pkg::ST_EMIT : tpds_pkg::ST_MUL;
          else if (attr_q == 2'd3) state_d = tpds_pkg::ST_EMIT;
          else state_d = tpds_pkg::ST_MUL;
        end
      end
      tpds_pkg::ST_EMIT:  if (out_load) state_d = tpds_pkg::ST_IDLE;
      default:            state_d = tpds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = (state_q == tpds_pkg::ST_IDLE) && !q_empty_i;
    out_load        = (state_q == tpds_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);
    div_req_o.start = (state_q == tpds_pkg::ST_DIVGO);
    div_req_o.num   = acc_q;
    div_req_o.den   = ent_q.full;
    ram_re_o        = pop_o && (head_i.op == tpds_pkg::OP_PIXEL);
    ram_we_o        = 1'b0;
    ram_addr_o      = head_i.idx[AW-1:0];
    ram_wdata_o     = {1'b1, dsat[tpds_pkg::DEPTH_W-1:0]};
    if (state_q == tpds_pkg::ST_SWEEP) begin
      ram_we_o    = 1'b1;
      ram_addr_o  = sw_q;
      ram_wdata_o = '0;
    end else if (state_q == tpds_pkg::ST_DIV && div_rsp_i.done && attr_q == 2'd0
                 && !depth_fail) begin
      ram_we_o   = 1'b1;
      ram_addr_o = ent_q.idx[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tpds_pkg::ST_SWEEP;
      sw_q         <= '0;
      sweep_emit_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tpds_pkg::ST_SWEEP) sw_q <= sw_q + 1'b1;
      if (pop_o && head_i.op == tpds_pkg::OP_CLEAR) begin
        sw_q         <= '0;
        sweep_emit_q <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q       <= head_i;
      attr_q      <= '0;
      mcnt_q      <= '0;
      acc_q       <= '0;
      res_drawn_q <= 1'b0;
      res_col_q   <= '0;
      res_depth_q <= '0;
    end
    if (state_q == tpds_pkg::ST_MUL) begin
      if (mcnt_q != 2'd3) prod_q <= mul_w * mul_a;
      if (mcnt_q != 2'd0) acc_q <= acc_q + tpds_pkg::ACC_W'(prod_q);
      mcnt_q <= mcnt_q + 1'b1;
    end
    if (state_q == tpds_pkg::ST_DIV && div_rsp_i.done) begin
      mcnt_q <= '0;
      acc_q  <= '0;
      attr_q <= attr_q + 1'b1;
      if (attr_q == 2'd0) begin
        if (!depth_fail) begin
          res_drawn_q <= 1'b1;
          res_depth_q <= dsat[tpds_pkg::DEPTH_W-1:0];
        end
      end else begin
        res_col_q[attr_q - 2'd1] <= csat[tpds_pkg::COLOR_W-1:0];
      end
    end
    if (out_load) begin
      out_drawn_q <= res_drawn_q;
      out_col_q   <= res_col_q;
      out_depth_q <= res_depth_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drawn       = out_drawn_q;
  assign out_o.pixel_red   = out_col_q[0];
  assign out_o.pixel_green = out_col_q[1];
  assign out_o.pixel_blue  = out_col_q[2];
  assign out_o.pixel_depth = out_depth_q;

  `TPDS_ASSERT(a_ram_one_access, ram_we_o |-> !ram_re_o)
  `TPDS_ASSERT(a_no_pop_in_sweep, (state_q == tpds_pkg::ST_SWEEP) |-> !pop_o)
  `TPDS_ASSERT(a_undrawn_zero, (out_valid_q && !out_drawn_q) |-> (out_depth_q == '0 && out_col_q == '0))
endmodule

### hw/rtl/triangle_pixel_depth_shader.sv
// A drawn pixel takes its 4 attributes in turn (multiply-accumulate, divide issue, divide);
//   a depth miss stops after the depth attribute. Load, kind 3, off-screen and rejected pixels go straight to emit.
// Throughput is set by the single multiplier and shared divider; one pixel at a time in back.
// A clear sweeps the depth store, one entry a cycle.
// Reset (rst_ni low, asynchronous) clears control and corners, then the same sweep runs
//   before pixels are processed; input is still queued.
module triangle_pixel_depth_shader #(
  parameter int SCREEN_WIDTH  = tpds_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tpds_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpds_in_if.sink    in_i,
  tpds_out_if.source out_o
);
  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic push, q_full, pop, q_empty;
  tpds_pkg::entry_t entry, head;
  tpds_pkg::div_req_t div_req;
  tpds_pkg::div_rsp_t div_rsp;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [tpds_pkg::STORE_W-1:0] ram_wdata, ram_rdata;

  tpds_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk_i, .rst_ni, .in_i, .q_full_i(q_full), .push_o(push), .entry_o(entry)
  );

  tpds_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .entry_i(entry), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .head_o(head)
  );

  tpds_back #(.DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .head_i(head), .pop_o(pop),
    .div_req_o(div_req), .div_rsp_i(div_rsp),
    .ram_we_o(ram_we), .ram_re_o(ram_re), .ram_addr_o(ram_addr),
    .ram_wdata_o(ram_wdata), .ram_rdata_i(ram_rdata), .out_o
  );

  tpds_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  tpds_ram #(.WIDTH(tpds_pkg::STORE_W), .DEPTH(DEPTH)) u_store (
    .clk_i, .we_i(ram_we), .re_i(ram_re), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );
endmodule

### tb/sv/triangle_pixel_depth_shader_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the triangle pixel depth shader: a queued driver, an output
// monitor and an in-bench pixel predictor with its own depth store.
// Depends on tpds_pkg, tpds_in_if / tpds_out_if and triangle_pixel_depth_shader.
module triangle_pixel_depth_shader_tb;

  localparam int  SCR_W         = 512;
  localparam int  SCR_H         = 512;
  localparam int  ITEM_TARGET   = 1950;
  localparam int  STALL_LIMIT   = 900000;
  localparam int  HOLD_CYCLES   = 400;
  localparam int  DRAIN_CYCLES  = 300;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic [1:0]         slot;
    logic [8:0]         x;
    logic [8:0]         y;
    logic signed [15:0] z;
    logic [11:0]        r;
    logic [11:0]        g;
    logic [11:0]        b;
  } shade_req_t;

  typedef struct {
    logic               drawn;
    logic [11:0]        r;
    logic [11:0]        g;
    logic [11:0]        b;
    logic signed [15:0] z;
  } shade_rsp_t;

  logic clk_i;
  logic rst_ni;

  tpds_in_if  in_if ();
  tpds_out_if out_if ();

  triangle_pixel_depth_shader dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  shade_req_t pending_q[$];
  shade_rsp_t shade_q[$];

  // predictor state
  longint corner_x[3], corner_y[3], corner_z[3];
  longint corner_rgb[3][3];
  int     zbuf[int];  // only entries that hold a depth

  int  n_items;
  int  n_in, n_out, n_drawn, n_err;
  int  hold_cnt;
  bit  hold_done;
  int  quiet_cnt;
  bit  in_taken;  // presented transaction accepted at the last rising edge

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic longint area2(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
    return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
  endfunction

  function automatic bit on_side(longint n, longint full);
    return (n == 0) || ((n > 0) == (full > 0));
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic shade_rsp_t shade_pixel(shade_req_t t);
    shade_rsp_t res;
    longint full, wa, wb, wg, dep, c;
    int idx;
    res = '{1'b0, '0, '0, '0, '0};
    case (t.kind)
      tpds_pkg::KIND_LOAD: begin
        if (t.slot < 3) begin
          corner_x[t.slot] = t.x;
          corner_y[t.slot] = t.y;
          corner_z[t.slot] = t.z;
          corner_rgb[t.slot][0] = t.r;
          corner_rgb[t.slot][1] = t.g;
          corner_rgb[t.slot][2] = t.b;
        end
      end
      tpds_pkg::KIND_CLEAR: zbuf.delete();
      tpds_pkg::KIND_PIXEL: begin
        full = area2(corner_x[0], corner_y[0], corner_x[1], corner_y[1],
                     corner_x[2], corner_y[2]);
        if (full == 0 || t.x >= SCR_W || t.y >= SCR_H) return res;
        wa = area2(corner_x[1], corner_y[1], corner_x[2], corner_y[2], t.x, t.y);
        wg = area2(corner_x[0], corner_y[0], corner_x[1], corner_y[1], t.x, t.y);
        wb = full - wa - wg;
        if (!on_side(wa, full) || !on_side(wb, full) || !on_side(wg, full)) return res;
        dep = sat((wa * corner_z[0] + wb * corner_z[1] + wg * corner_z[2]) / full,
                  -32767, 32767);
        idx = int'(t.x) + int'(t.y) * SCR_W;
        if (zbuf.exists(idx) && zbuf[idx] > dep) return res;
        zbuf[idx] = int'(dep);
        res.drawn = 1'b1;
        res.z = 16'(dep);
        c = sat((wa * corner_rgb[0][0] + wb * corner_rgb[1][0] + wg * corner_rgb[2][0])
                / full, 0, 4095);
        res.r = 12'(c);
        c = sat((wa * corner_rgb[0][1] + wb * corner_rgb[1][1] + wg * corner_rgb[2][1])
                / full, 0, 4095);
        res.g = 12'(c);
        c = sat((wa * corner_rgb[0][2] + wb * corner_rgb[1][2] + wg * corner_rgb[2][2])
                / full, 0, 4095);
        res.b = 12'(c);
      end
      default: ;
    endcase
    return res;
  endfunction

  // 0: sender 28 % idle, receiver 88 %; 1: reversed; 2: no idling
  function automatic int idle_phase();
    if (n_in < n_items / 3) return 0;
    if (n_in < (2 * n_items) / 3) return 1;
    return 2;
  endfunction

  task automatic add_item(logic [1:0] kind, int slot, int x, int y, int z,
                          int r, int g, int b);
    shade_req_t t;
    t.kind = kind; t.slot = 2'(slot); t.x = 9'(x); t.y = 9'(y); t.z = 16'(z);
    t.r = 12'(r); t.g = 12'(g); t.b = 12'(b);
    pending_q.push_back(t);
  endtask

  task automatic add_random_vertex(int slot, int bx, int by, int span);
    add_item(tpds_pkg::KIND_LOAD, slot, (bx + $urandom_range(0, span)) % SCR_W,
             (by + $urandom_range(0, span)) % SCR_H, int'(16'($urandom)),
             $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  // driver: presents queued transactions at the falling edge
  always @(negedge clk_i) begin
    shade_req_t t;
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (pending_q.size() != 0 &&
          !(idle_phase() == 0 && $urandom_range(0, 99) < 28) &&
          !(idle_phase() == 1 && $urandom_range(0, 99) < 88)) begin
        t = pending_q.pop_front();
        in_if.kind            <= t.kind;
        in_if.vertex_slot     <= t.slot;
        in_if.pos_x           <= t.x;
        in_if.pos_y           <= t.y;
        in_if.vertex_depth_in <= t.z;
        in_if.vertex_red      <= t.r;
        in_if.vertex_green    <= t.g;
        in_if.vertex_blue     <= t.b;
        in_if.valid           <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold-off once idling stops
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (idle_phase() == 2 && !hold_done && n_in > 0) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (idle_phase() == 0) begin
      out_if.ready <= ($urandom_range(0, 99) >= 88);
    end else if (idle_phase() == 1) begin
      out_if.ready <= ($urandom_range(0, 99) >= 28);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor: predicts on accepted input, checks accepted output
  always @(posedge clk_i) begin
    shade_req_t t;
    shade_rsp_t e;
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      quiet_cnt = quiet_cnt + 1;
      if (in_if.valid && in_if.ready) begin
        t.kind = in_if.kind; t.slot = in_if.vertex_slot;
        t.x = in_if.pos_x; t.y = in_if.pos_y; t.z = in_if.vertex_depth_in;
        t.r = in_if.vertex_red; t.g = in_if.vertex_green; t.b = in_if.vertex_blue;
        shade_q.push_back(shade_pixel(t));
        n_in = n_in + 1;
        quiet_cnt = 0;
      end
      if (out_if.valid && out_if.ready) begin
        quiet_cnt = 0;
        n_out = n_out + 1;
        if (shade_q.size() == 0) begin
          $error("result transaction with nothing expected");
          n_err = n_err + 1;
        end else begin
          e = shade_q.pop_front();
          if (e.drawn) n_drawn = n_drawn + 1;
          if (out_if.drawn !== e.drawn) begin
            $error("drawn: expected %0d, got %0d", e.drawn, out_if.drawn);
            n_err = n_err + 1;
          end
          if (out_if.pixel_red !== e.r) begin
            $error("pixel_red: expected %0d, got %0d", e.r, out_if.pixel_red);
            n_err = n_err + 1;
          end
          if (out_if.pixel_green !== e.g) begin
            $error("pixel_green: expected %0d, got %0d", e.g, out_if.pixel_green);
            n_err = n_err + 1;
          end
          if (out_if.pixel_blue !== e.b) begin
            $error("pixel_blue: expected %0d, got %0d", e.b, out_if.pixel_blue);
            n_err = n_err + 1;
          end
          if (out_if.pixel_depth !== e.z) begin
            $error("pixel_depth: expected %0d, got %0d", e.z, out_if.pixel_depth);
            n_err = n_err + 1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int bx, by, span, npix, cx, cy;
    bit cleared;
    in_if.valid = 1'b0; in_if.kind = tpds_pkg::KIND_LOAD; in_if.vertex_slot = '0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.vertex_depth_in = '0;
    in_if.vertex_red = '0; in_if.vertex_green = '0; in_if.vertex_blue = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    n_in = 0; n_out = 0; n_drawn = 0; n_err = 0; n_items = 0;
    hold_cnt = 0; hold_done = 1'b0; quiet_cnt = 0; cleared = 1'b0; in_taken = 1'b0;
    for (int i = 0; i < 3; i++) begin
      corner_x[i] = 0; corner_y[i] = 0; corner_z[i] = 0;
      for (int k = 0; k < 3; k++) corner_rgb[i][k] = 0;
    end

    // directed: degenerate reset triangle, field extremes, spare codes, equal depth
    add_item(tpds_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_LOAD, 0, 0, 0, 32767, 4095, 4095, 4095);
    add_item(tpds_pkg::KIND_LOAD, 1, 511, 0, -32768, 0, 0, 0);
    add_item(tpds_pkg::KIND_LOAD, 2, 0, 511, -32768, 2048, 0, 4095);
    add_item(tpds_pkg::KIND_LOAD, 3, 300, 300, 100, 1, 2, 3);
    add_item(KIND_SPARE, 3, 511, 511, -1, 4095, 4095, 4095);
    add_item(tpds_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 511, 511, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 100, 100, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 100, 100, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 511, 0, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 255, 256, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 100, 100, 0, 0, 0, 0);
    // reversed winding, nearer depth over the same spot
    add_item(tpds_pkg::KIND_LOAD, 1, 0, 511, 32767, 100, 200, 300);
    add_item(tpds_pkg::KIND_LOAD, 2, 511, 0, 32767, 4095, 0, 4095);
    add_item(tpds_pkg::KIND_PIXEL, 0, 100, 100, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 1, 1, 0, 0, 0, 0);
    // corner 2 moved onto the old edge from corner 1 to corner 2
    add_item(tpds_pkg::KIND_LOAD, 2, 255, 256, 0, 0, 0, 0);
    add_item(tpds_pkg::KIND_PIXEL, 0, 10, 10, 0, 0, 0, 0);

    // random: triangles of random size followed by pixels around them
    while (pending_q.size() < ITEM_TARGET) begin
      span = ($urandom_range(0, 15) == 0) ? 511 : $urandom_range(2, 40);
      bx = $urandom_range(0, 511);
      by = $urandom_range(0, 511);
      if ($urandom_range(0, 9) == 0) begin
        add_random_vertex($urandom_range(0, 3), bx, by, span);
      end else begin
        for (int v = 0; v < 3; v++) add_random_vertex(v, bx, by, span);
      end
      if (!cleared && pending_q.size() > ITEM_TARGET / 2) begin
        add_item(tpds_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        cleared = 1'b1;
      end
      npix = $urandom_range(4, 24);
      for (int p = 0; p < npix; p++) begin
        if ($urandom_range(0, 19) == 0) begin
          add_item(KIND_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        end else if ($urandom_range(0, 9) == 0) begin
          add_item(tpds_pkg::KIND_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        end else begin
          cx = (bx + $urandom_range(0, span)) % SCR_W;
          cy = (by + $urandom_range(0, span)) % SCR_H;
          add_item(tpds_pkg::KIND_PIXEL, $urandom, cx, cy, $urandom, $urandom, $urandom,
                   $urandom);
          // revisit the spot: equal depth must draw again
          if ($urandom_range(0, 7) == 0)
            add_item(tpds_pkg::KIND_PIXEL, 0, cx, cy, 0, 0, 0, 0);
        end
      end
    end
    n_items = pending_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // pending_q is popped on presentation, so also wait for the last acceptance
    while (pending_q.size() != 0 || in_if.valid || shade_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input transactions, %0d results, %0d pixels drawn,", n_in,
             n_out, n_drawn);
    $display("through three idling phases, one long receiver hold-off and depth clears");
    if (n_err == 0 && shade_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
